/* src/nwe_pkg.sv */
// Shared constants for the weighted normal-equation builder.
package nwe_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 80;
  localparam int DIVD_W = 65;
  localparam int DIVR_W = 62;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_PARAMS = 8;

  localparam logic [2:0] ACT_RESIDUAL = 3'd0;
  localparam logic [2:0] ACT_DERIV    = 3'd1;
  localparam logic [2:0] ACT_WEIGHT   = 3'd2;
  localparam logic [2:0] ACT_PARAM    = 3'd3;
  localparam logic [2:0] ACT_START    = 3'd4;

  localparam logic [1:0] WM_DIAG = 2'd1;
  localparam logic [1:0] WM_FULL = 2'd2;

  localparam logic [1:0] CFG_WEIGHT_MODE = 2'd0;
  localparam logic [1:0] CFG_NUM_POINTS  = 2'd1;
  localparam logic [1:0] CFG_NUM_PARAMS  = 2'd2;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

endpackage

/* src/nwe_ram.sv */
// Single-port-write, single-port-read memory with registered read data.
module nwe_ram
  import nwe_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/nwe_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module nwe_div
  import nwe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r, dvs_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIVD_W-2:0], ge};
      rem_nxt  = ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      cnt_nxt  = cnt_r - 7'd1;
      busy_nxt = (cnt_r != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* src/weighted_normal_equation_builder_top.sv */
// Top level: load stores, sequencer, shared multiplier and accumulator.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | action, row, col, value, prior fields
//  out_    | output    | out_valid/out_stall | kind, row_index, col_index, sum_value, last
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// Load items are written when accepted. A start item uses one shared 33x33 multiplier:
// an entry has a setup step, then per product term a read, three multiplies and an
// accumulate over n terms (n*n in full weight mode), a prior check, a prior term when
// needed (square, divider start, divide steps, add), an emit and a wait until taken.
// Reset sets control, configuration and prior flags to defaults; stores hold their data.
// in_stall is high during a run and while a result item waits on out_stall.
module weighted_normal_equation_builder_top
  import nwe_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic               in_prior_valid,
  input  logic signed [31:0] in_prior_center,
  input  logic [30:0]        in_prior_error,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [2:0]         out_row_index,
  output logic [2:0]         out_col_index,
  output logic signed [63:0] out_sum_value,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int PW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int DAW = (MAX_PARAMS * MAX_POINTS > 1) ? $clog2(MAX_PARAMS * MAX_POINTS) : 1;
  localparam int WAW = (MAX_POINTS * MAX_POINTS > 1) ? $clog2(MAX_POINTS * MAX_POINTS) : 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ENTRY = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_MUL1  = 13'b0000000001000,
    S_MUL2  = 13'b0000000010000,
    S_MUL3  = 13'b0000000100000,
    S_ACC   = 13'b0000001000000,
    S_PRI   = 13'b0000010000000,
    S_ESQ   = 13'b0000100000000,
    S_DIVS  = 13'b0001000000000,
    S_DIVW  = 13'b0010000000000,
    S_EMIT  = 13'b0100000000000,
    S_OUTW  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0] weight_mode_r;
  logic [6:0] num_points_r;
  logic [3:0] num_params_r;

  logic [NW-1:0] n_r, n_nxt;
  logic [3:0]    np_r, np_nxt;
  logic [2:0]    p_r, p_nxt;
  logic [2:0]    q_r, q_nxt;
  logic          grad_r, grad_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic          prior_neg_r, prior_neg_nxt;
  logic [63:0]   pr_r, pr_nxt;
  logic [64:0]   l_r, l_nxt;
  logic [63:0]   h_r, h_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [2:0]    out_row_r, out_row_nxt;
  logic [2:0]    out_col_r, out_col_nxt;
  logic [63:0]   out_sum_r, out_sum_nxt;
  logic          out_last_r, out_last_nxt;

  logic [31:0] param_r [MAX_PARAMS];
  logic [31:0] center_r [MAX_PARAMS];
  logic [30:0] perr_r [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] pflag_r;

  logic in_acc, out_acc;
  logic row_pok, row_mok, col_mok;
  logic res_we, der_we, wt_we, par_we;
  logic full_w, diag_w;
  logic [IW-1:0] xi;
  logic rd_en;

  logic [IW-1:0]     res_raddr;
  logic [DAW-1:0]    der_waddr, dera_raddr, derb_raddr;
  logic [WAW-1:0]    wt_waddr, wt_raddr;
  logic [DATA_W-1:0] res_rdata, dera_rdata, derb_rdata, wt_rdata;
  logic [31:0]       x_val, w_val;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic [65:0]        term;
  logic [ACC_W-1:0]   addend;
  logic               add_neg;

  logic [PW-1:0] pix;
  logic [32:0]   dlt, dmag;
  logic [30:0]   e_val;
  logic          div_start, div_busy;
  logic [DIVD_W-1:0] div_dividend, div_quo;
  logic [8:0]    npts9;
  logic          i_last, j_last, q_last, p_last;
  logic [63:0]   sat_sum;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  assign row_pok = 9'(in_row) < 9'(MAX_PARAMS);
  assign row_mok = 9'(in_row) < 9'(MAX_POINTS);
  assign col_mok = 9'(in_col) < 9'(MAX_POINTS);
  assign res_we  = in_acc && (in_action == ACT_RESIDUAL) && col_mok;
  assign der_we  = in_acc && (in_action == ACT_DERIV) && row_pok && col_mok;
  assign wt_we   = in_acc && (in_action == ACT_WEIGHT) && row_mok && col_mok;
  assign par_we  = in_acc && (in_action == ACT_PARAM) && row_pok;

  assign full_w = (weight_mode_r == WM_FULL);
  assign diag_w = (weight_mode_r == WM_DIAG);
  assign xi     = full_w ? j_r : i_r;
  assign rd_en  = (state_r == S_RD);

  assign der_waddr  = DAW'(in_row) * DAW'(MAX_POINTS) + DAW'(in_col);
  assign wt_waddr   = WAW'(in_row) * WAW'(MAX_POINTS) + WAW'(in_col);
  assign dera_raddr = DAW'(p_r) * DAW'(MAX_POINTS) + DAW'(i_r);
  assign derb_raddr = DAW'(q_r) * DAW'(MAX_POINTS) + DAW'(xi);
  assign res_raddr  = xi;
  assign wt_raddr   = full_w ? (WAW'(i_r) * WAW'(MAX_POINTS) + WAW'(j_r)) : WAW'(i_r);

  nwe_ram #(.DEPTH(MAX_POINTS), .AW(IW)) u_res (
    .clk(clk), .we(res_we), .waddr(IW'(in_col)), .wdata(in_value),
    .re(rd_en), .raddr(res_raddr), .rdata(res_rdata)
  );

  // two copies of the derivative rows give the p and q reads in the same cycle
  nwe_ram #(.DEPTH(MAX_PARAMS * MAX_POINTS), .AW(DAW)) u_dera (
    .clk(clk), .we(der_we), .waddr(der_waddr), .wdata(in_value),
    .re(rd_en), .raddr(dera_raddr), .rdata(dera_rdata)
  );

  nwe_ram #(.DEPTH(MAX_PARAMS * MAX_POINTS), .AW(DAW)) u_derb (
    .clk(clk), .we(der_we), .waddr(der_waddr), .wdata(in_value),
    .re(rd_en), .raddr(derb_raddr), .rdata(derb_rdata)
  );

  nwe_ram #(.DEPTH(MAX_POINTS * MAX_POINTS), .AW(WAW)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(in_value),
    .re(rd_en), .raddr(wt_raddr), .rdata(wt_rdata)
  );

  assign x_val = grad_r ? res_rdata : derb_rdata;
  assign w_val = (full_w || diag_w) ? wt_rdata : ONE_Q16;

  assign pix   = p_r[PW-1:0];
  assign e_val = (perr_r[pix] == 31'd0) ? 31'd1 : perr_r[pix];
  assign dlt   = {param_r[pix][31], param_r[pix]} - {center_r[pix][31], center_r[pix]};
  assign dmag  = dlt[32] ? (33'd0 - dlt) : dlt;
  assign div_dividend = grad_r ? {dmag, 32'd0} : (65'd1 << 48);
  assign div_start    = (state_r == S_DIVS);

  nwe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(pr_r[DIVR_W-1:0]), .busy(div_busy), .quotient(div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MUL1: begin
        ma = $signed({dera_rdata[31], dera_rdata});
        mb = $signed({w_val[31], w_val});
      end
      S_MUL2: begin
        ma = $signed({1'b0, pr_r[31:0]});
        mb = $signed({x_val[31], x_val});
      end
      S_MUL3: begin
        ma = $signed({pr_r[63], pr_r[63:32]});
        mb = $signed({x_val[31], x_val});
      end
      default: begin
        ma = $signed({2'b00, e_val});
        mb = $signed({2'b00, e_val});
      end
    endcase
  end
  assign mprod = ma * mb;

  // floor of the triple product over 2^32: high partial plus carried-down low partial
  assign term = {{2{h_r[63]}}, h_r} + {{33{l_r[64]}}, l_r[64:32]};

  always_comb begin
    if (state_r == S_DIVW) begin
      addend  = {{(ACC_W-DIVD_W){1'b0}}, div_quo};
      add_neg = prior_neg_r;
    end else begin
      addend  = {{(ACC_W-66){term[65]}}, term};
      add_neg = !grad_r;
    end
  end

  always_comb begin
    if ((&acc_r[ACC_W-1:63]) || !(|acc_r[ACC_W-1:63])) begin
      sat_sum = acc_r[63:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_sum = 64'h8000_0000_0000_0000;
    end else begin
      sat_sum = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  assign npts9  = {2'b00, num_points_r};
  assign i_last = (NW'(i_r) == n_r - NW'(1));
  assign j_last = (NW'(j_r) == n_r - NW'(1));
  assign q_last = ({1'b0, q_r} == np_r - 4'd1);
  assign p_last = ({1'b0, p_r} == np_r - 4'd1);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    np_nxt        = np_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    grad_nxt      = grad_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    prior_neg_nxt = prior_neg_r;
    pr_nxt        = pr_r;
    l_nxt         = l_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == ACT_START)) begin
          n_nxt    = (npts9 > 9'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(npts9);
          np_nxt   = (num_params_r > 4'(MAX_PARAMS)) ? 4'(MAX_PARAMS) : num_params_r;
          p_nxt    = '0;
          q_nxt    = '0;
          grad_nxt = 1'b1;
          if (np_nxt != 4'd0) begin
            state_nxt = S_ENTRY;
          end
        end
      end
      S_ENTRY: begin
        acc_nxt   = '0;
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = (n_r == '0) ? S_PRI : S_RD;
      end
      S_RD: state_nxt = S_MUL1;
      S_MUL1: begin
        pr_nxt    = mprod[63:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        l_nxt     = mprod[64:0];
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        h_nxt     = mprod[63:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = add_neg ? (acc_r - addend) : (acc_r + addend);
        if (full_w && !j_last) begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_RD;
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_RD;
          end else begin
            state_nxt = S_PRI;
          end
        end
      end
      S_PRI: begin
        state_nxt = (pflag_r[pix] && (grad_r || (q_r == p_r))) ? S_ESQ : S_EMIT;
      end
      S_ESQ: begin
        pr_nxt    = mprod[63:0];
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        prior_neg_nxt = grad_r ? dlt[32] : 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (!div_busy) begin
          acc_nxt   = add_neg ? (acc_r - addend) : (acc_r + addend);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = !grad_r;
        out_row_nxt   = p_r;
        out_col_nxt   = grad_r ? p_r : q_r;
        out_sum_nxt   = sat_sum;
        out_last_nxt  = !grad_r && q_last && p_last;
        state_nxt     = (!grad_r && q_last && p_last) ? S_IDLE : S_OUTW;
      end
      S_OUTW: begin
        if (out_acc) begin
          state_nxt = S_ENTRY;
          if (grad_r) begin
            grad_nxt = 1'b0;
            q_nxt    = p_r;
          end else if (!q_last) begin
            q_nxt = q_r + 3'd1;
          end else begin
            p_nxt    = p_r + 3'd1;
            grad_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      weight_mode_r <= 2'd0;
      num_points_r  <= 7'd64;
      num_params_r  <= 4'd8;
      pflag_r       <= '0;
      acc_r         <= '0;
      p_r           <= '0;
      q_r           <= '0;
      grad_r        <= 1'b0;
      i_r           <= '0;
      j_r           <= '0;
      n_r           <= '0;
      np_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      grad_r      <= grad_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      np_r        <= np_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WEIGHT_MODE: weight_mode_r <= cfg_wdata[1:0];
          CFG_NUM_POINTS:  num_points_r  <= cfg_wdata;
          CFG_NUM_PARAMS:  num_params_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (par_we) begin
        pflag_r[in_row[PW-1:0]] <= in_prior_valid;
      end
    end
    prior_neg_r <= prior_neg_nxt;
    pr_r        <= pr_nxt;
    l_r         <= l_nxt;
    h_r         <= h_nxt;
    out_kind_r  <= out_kind_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_sum_r   <= out_sum_nxt;
    out_last_r  <= out_last_nxt;
    if (par_we) begin
      param_r[in_row[PW-1:0]]  <= in_value;
      center_r[in_row[PW-1:0]] <= in_prior_center;
      perr_r[in_row[PW-1:0]]   <= in_prior_error;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_sum_value = out_sum_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIVW))
    else $error("divider busy outside its wait state");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == S_IDLE))
    else $error("run still active after its final item");

  a_acc_needs_points: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (n_r != '0))
    else $error("accumulate step with no data points");

  a_emit_after_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !out_valid_r)
    else $error("result item overwritten before it was taken");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the weighted normal-equation builder.
module testbench;
  import nwe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = DEF_MAX_POINTS;
  localparam int NPAR = DEF_MAX_PARAMS;
  localparam longint CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic signed [127:0] SAT_HI = {64'h0, 64'h7fff_ffff_ffff_ffff};
  localparam logic signed [127:0] SAT_LO = {{64{1'b1}}, 64'h8000_0000_0000_0000};

  typedef struct {
    logic [2:0]  action;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    logic        prior_valid;
    logic [31:0] prior_center;
    logic [30:0] prior_error;
  } load_item_t;

  typedef struct {
    logic        kind;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [63:0] sum_value;
    logic        last;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [5:0] in_row = '0;
  logic [5:0] in_col = '0;
  logic signed [31:0] in_value = '0;
  logic in_prior_valid = 1'b0;
  logic signed [31:0] in_prior_center = '0;
  logic [30:0] in_prior_error = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_kind;
  logic [2:0] out_row_index;
  logic [2:0] out_col_index;
  logic signed [63:0] out_sum_value;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  weighted_normal_equation_builder_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's stores and registers
  logic [31:0] res_mem [NPTS];
  logic [31:0] der_mem [NPAR*NPTS];
  logic [31:0] wt_mem [NPTS*NPTS];
  logic [31:0] par_mem [NPAR];
  logic        pflag_mem [NPAR];
  logic [31:0] pctr_mem [NPAR];
  logic [30:0] perr_mem [NPAR];
  logic [1:0]  mode_reg = 2'd0;
  logic [6:0]  npts_reg = 7'd64;
  logic [3:0]  npar_reg = 4'd8;

  load_item_t pending_q[$];
  entry_t     entry_q[$];
  int         fails = 0;
  int         results_seen = 0;
  longint     cycles = 0;

  initial begin
    for (int i = 0; i < NPAR; i++) pflag_mem[i] = 1'b0;
  end

  function automatic logic signed [127:0] term3(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c);
    logic signed [127:0] x, y, z;
    x = {{96{a[31]}}, a};
    y = {{96{b[31]}}, b};
    z = {{96{c[31]}}, c};
    return (x * y * z) >>> 32;
  endfunction

  // sum of df[p] * W * x, where x is the residuals or df[q]
  function automatic logic signed [127:0] dot_sum(int p, bit with_res, int q, int n);
    logic signed [127:0] s;
    logic [31:0] d, xv;
    s = '0;
    for (int i = 0; i < n; i++) begin
      d = der_mem[p*NPTS+i];
      if (mode_reg == WM_FULL) begin
        for (int j = 0; j < n; j++) begin
          xv = with_res ? res_mem[j] : der_mem[q*NPTS+j];
          s += term3(d, wt_mem[i*NPTS+j], xv);
        end
      end else begin
        xv = with_res ? res_mem[i] : der_mem[q*NPTS+i];
        s += term3(d, (mode_reg == WM_DIAG) ? wt_mem[i] : ONE_Q16, xv);
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] clamp64(logic signed [127:0] s);
    if (s > SAT_HI) return SAT_HI[63:0];
    if (s < SAT_LO) return SAT_LO[63:0];
    return s[63:0];
  endfunction

  function automatic logic [127:0] err_sq(int p);
    logic [127:0] e;
    e = {97'd0, perr_mem[p]};
    if (e == '0) e = 128'd1;
    return e * e;
  endfunction

  task automatic build_entries();
    int n, np;
    logic signed [127:0] s, d, qv;
    logic [127:0] dm;
    entry_t e;
    n = (int'(npts_reg) > NPTS) ? NPTS : int'(npts_reg);
    np = (int'(npar_reg) > NPAR) ? NPAR : int'(npar_reg);
    for (int p = 0; p < np; p++) begin
      s = dot_sum(p, 1'b1, 0, n);
      if (pflag_mem[p]) begin
        d = $signed({{96{par_mem[p][31]}}, par_mem[p]}) -
            $signed({{96{pctr_mem[p][31]}}, pctr_mem[p]});
        dm = (d < 0) ? -d : d;
        qv = $signed((dm << 32) / err_sq(p));
        s = (d < 0) ? s - qv : s + qv;
      end
      e = '{1'b0, p[2:0], p[2:0], clamp64(s), 1'b0};
      entry_q.push_back(e);
      for (int q = p; q < np; q++) begin
        s = -dot_sum(p, 1'b0, q, n);
        if (p == q && pflag_mem[p]) s -= $signed((128'd1 << 48) / err_sq(p));
        e = '{1'b1, p[2:0], q[2:0], clamp64(s), 1'b0};
        entry_q.push_back(e);
      end
    end
    if (np > 0) entry_q[entry_q.size()-1].last = 1'b1;
  endtask

  // input side: update the shadow on every accepted item
  logic in_fire = 1'b0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      case (in_action)
        ACT_RESIDUAL: res_mem[in_col] = in_value;
        ACT_DERIV: if (in_row < NPAR) der_mem[in_row*NPTS+in_col] = in_value;
        ACT_WEIGHT: wt_mem[in_row*NPTS+in_col] = in_value;
        ACT_PARAM: if (in_row < NPAR) begin
          par_mem[in_row] = in_value;
          pflag_mem[in_row] = in_prior_valid;
          pctr_mem[in_row] = in_prior_center;
          perr_mem[in_row] = in_prior_error;
        end
        ACT_START: build_entries();
        default: ;
      endcase
    end
  end

  // driver
  int  in_gap = 0;
  bit  in_burst = 0;
  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic present(load_item_t it);
    in_valid <= 1'b1;
    in_action <= it.action;
    in_row <= it.row;
    in_col <= it.col;
    in_value <= it.value;
    in_prior_valid <= it.prior_valid;
    in_prior_center <= it.prior_center;
    in_prior_error <= it.prior_error;
  endtask

  always @(negedge clk) begin
    int g;
    if ($urandom_range(0, 19) == 0) in_burst <= ~in_burst;
    if (in_valid && in_fire) begin
      g = draw_gap(in_burst);
      if (g == 0 && pending_q.size() > 0) present(pending_q.pop_front());
      else begin
        in_valid <= 1'b0;
        in_gap <= g;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) in_gap <= in_gap - 1;
      else if (pending_q.size() > 0 && rst_n) present(pending_q.pop_front());
    end
  end

  // result side
  logic out_fire = 1'b0;
  int   out_wait = 0;
  int   long_hold = 0;
  bit   long_done = 0;
  bit   out_burst = 0;

  always @(posedge clk) begin
    entry_t e;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (entry_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        e = entry_q.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_kind); fails++;
        end
        if (out_row_index !== e.row_index) begin
          $error("row_index expected %0d actual %0d", e.row_index, out_row_index); fails++;
        end
        if (out_col_index !== e.col_index) begin
          $error("col_index expected %0d actual %0d", e.col_index, out_col_index); fails++;
        end
        if (out_sum_value !== e.sum_value) begin
          $error("sum_value expected %h actual %h", e.sum_value, out_sum_value); fails++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); fails++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int g;
    g = draw_gap(out_burst);
    if ($urandom_range(0, 19) == 0) out_burst <= ~out_burst;
    if (!rst_n) out_stall <= 1'b1;
    else if (!long_done && results_seen == 5) begin
      // hold off long enough for the block to back up its input
      long_done <= 1;
      long_hold <= 600;
      out_stall <= 1'b1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else if (out_fire) begin
      out_wait <= g;
      out_stall <= (g != 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end else out_stall <= 1'b0;
  end

  function automatic load_item_t mk(logic [2:0] a, logic [5:0] r, logic [5:0] c,
                                    logic [31:0] v, logic pv = 1'b0,
                                    logic [31:0] pc = 32'd0,
                                    logic [30:0] pe = 31'h10000);
    load_item_t it;
    it = '{a, r, c, v, pv, pc, pe};
    return it;
  endfunction

  function automatic load_item_t rand_item(int n, int np, int noise);
    load_item_t it;
    it = mk(3'($urandom_range(0, 3)), 6'd0, 6'd0, $urandom(), 1'($urandom_range(0, 1)),
            $urandom(),
            ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 255)) : 31'($urandom()));
    if ($urandom_range(0, 99) < noise) begin
      it.row = 6'($urandom());
      it.col = 6'($urandom());
    end else begin
      it.row = (it.action == ACT_WEIGHT) ? 6'($urandom_range(0, n-1))
                                         : 6'($urandom_range(0, np-1));
      it.col = 6'($urandom_range(0, n-1));
    end
    if ($urandom_range(0, 7) == 0) it.value = $urandom_range(0, 1) ? 32'h7fffffff
                                                                   : 32'h80000000;
    return it;
  endfunction

  task automatic wait_drained();
    wait (pending_q.size() == 0 && !in_valid && entry_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [6:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    case (idx)
      CFG_WEIGHT_MODE: mode_reg = v[1:0];
      CFG_NUM_POINTS: npts_reg = v;
      CFG_NUM_PARAMS: npar_reg = v[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [1:0] m, logic [6:0] n, logic [3:0] np);
    wait_drained();
    set_reg(CFG_WEIGHT_MODE, {5'd0, m});
    set_reg(CFG_NUM_POINTS, n);
    set_reg(CFG_NUM_PARAMS, {3'd0, np});
  endtask

  initial begin
    int n, np, m, cnt;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // keep starts to a few points so a small fill covers every entry they read
    configure(2'd0, 7'd4, 4'd8);
    for (int i = 0; i < 4; i++)
      pending_q.push_back(mk(ACT_RESIDUAL, 6'd0, 6'(i), $urandom()));
    for (int p = 0; p < NPAR; p++)
      for (int i = 0; i < 4; i++)
        pending_q.push_back(mk(ACT_DERIV, 6'(p), 6'(i), $urandom()));
    for (int c = 0; c < 4; c++)
      pending_q.push_back(mk(ACT_WEIGHT, 6'd0, 6'(c), $urandom()));
    for (int r = 1; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pending_q.push_back(mk(ACT_WEIGHT, 6'(r), 6'(c), $urandom()));

    // directed: value extremes, prior corners, ignored items
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    pending_q.push_back(mk(ACT_RESIDUAL, 6'd63, 6'd0, 32'h80000000));
    pending_q.push_back(mk(ACT_RESIDUAL, 6'd0, 6'd63, 32'h7fffffff));
    pending_q.push_back(mk(ACT_DERIV, 6'd7, 6'd0, 32'h80000000));
    pending_q.push_back(mk(ACT_DERIV, 6'd0, 6'd63, 32'h7fffffff));
    pending_q.push_back(mk(ACT_WEIGHT, 6'd0, 6'd0, 32'h80000000));
    pending_q.push_back(mk(ACT_WEIGHT, 6'd63, 6'd63, 32'h7fffffff));
    // zero prior error acts as the smallest step
    pending_q.push_back(mk(ACT_PARAM, 6'd0, 6'd0, 32'h7fffffff, 1'b1, 32'h80000000, 31'd0));
    pending_q.push_back(mk(ACT_PARAM, 6'd7, 6'd0, 32'h80000000, 1'b1, 32'h7fffffff,
                           31'h7fffffff));
    pending_q.push_back(mk(ACT_PARAM, 6'd1, 6'd0, 32'h00010000, 1'b1, 32'hfffe0000, 31'd1));
    pending_q.push_back(mk(ACT_PARAM, 6'd63, 6'd0, 32'hffffffff, 1'b1, 32'hffffffff,
                           31'h7fffffff));
    pending_q.push_back(mk(ACT_DERIV, 6'd63, 6'd63, 32'hffffffff));
    pending_q.push_back(mk(3'd5, 6'd63, 6'd63, 32'hffffffff));
    pending_q.push_back(mk(3'd6, 6'd0, 6'd0, 32'd0));
    pending_q.push_back(mk(3'd7, 6'd21, 6'd42, 32'h55555555));
    pending_q.push_back(mk(ACT_START, 6'd63, 6'd63, 32'hffffffff, 1'b1, 32'hffffffff,
                           31'h7fffffff));
    configure(WM_DIAG, 7'd1, 4'd1);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    configure(WM_FULL, 7'd3, 4'd3);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    // oversized parameter count clamps; mode three behaves as unweighted
    configure(2'd3, 7'd4, 4'd15);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    configure(2'd0, 7'd0, 4'd0);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    configure(WM_FULL, 7'd0, 4'd2);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
    configure(WM_FULL, 7'd3, 4'd8);
    pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));

    // random phases: loads with random content and starts mixed, then a closing start
    cnt = 0;
    while (cnt < 110) begin
      m = $urandom_range(0, 2);
      np = $urandom_range(1, 8);
      if (m == 2) n = $urandom_range(1, 3);
      else n = $urandom_range(1, 4);
      configure(m[1:0], n[6:0], np[3:0]);
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          pending_q.push_back(mk(ACT_START, 6'($urandom()), 6'($urandom()), $urandom()));
          cnt++;
        end else if ($urandom_range(0, 99) < 4) begin
          pending_q.push_back(mk(3'($urandom_range(5, 7)), 6'($urandom()), 6'($urandom()),
                                 $urandom()));
        end else begin
          pending_q.push_back(rand_item(n, np, 10));
          cnt++;
        end
      end
      pending_q.push_back(mk(ACT_START, 6'd0, 6'd0, 32'd0));
      cnt++;
    end

    wait_drained();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
